>>> src/rwps_pkg.sv
// Shared types, widths and constants of the ring window percentile selector.
`timescale 1ns / 1ps

package rwps_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned LEN_W  = 11;

  // Default sizes handed to the top level parameters
  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned MAX_WINDOW_DEF = 256;

  // Ring length register after reset
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // One input item
  typedef struct packed {
    logic                     cmd;
    logic [SLOT_W-1:0]        write_slot;
    logic signed [DATA_W-1:0] sample_value;
    logic [IDX_W-1:0]         window_begin;
    logic [IDX_W-1:0]         window_end;
  } rwps_item_t;

  // One result item
  typedef struct packed {
    logic signed [DATA_W-1:0] reference_value;
    logic                     window_too_long;
  } rwps_result_t;

  // Contents of one sorting cell
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } rwps_slot_t;

  // Operation broadcast to every sorting cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } rwps_cell_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_WRITE,
    ST_MOD_QUERY,
    ST_SINGLE_RD,
    ST_SINGLE_OUT,
    ST_FILL,
    ST_DRAIN,
    ST_SELECT
  } rwps_state_e;

endpackage

>>> src/rwps_ring.sv
// Sample ring storage: one write port, one registered read port.
`timescale 1ns / 1ps

module rwps_ring #(
  parameter int unsigned RING_DEPTH = rwps_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW        = $clog2(RING_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [rwps_pkg::DATA_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [rwps_pkg::DATA_W-1:0] rdata_o
);

  logic [rwps_pkg::DATA_W-1:0] mem [RING_DEPTH];
  logic [rwps_pkg::DATA_W-1:0] rdata_q;

  // Store a sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rwps_mod.sv
// Iterative remainder unit: one quotient bit per cycle over the 16-bit dividend.
`timescale 1ns / 1ps

module rwps_mod #(
  parameter int unsigned DIV_W = 17,
  localparam int unsigned CNT_W = $clog2(rwps_pkg::IDX_W)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rwps_pkg::IDX_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [DIV_W-1:0]           rem_o
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rwps_pkg::IDX_W - 1);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [rwps_pkg::IDX_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]           div_q, div_d;
  logic [DIV_W-1:0]           rem_q, rem_d;
  logic [DIV_W:0]             trial;
  logic [DIV_W:0]             diff;

  // Shift in the next dividend bit and subtract where it fits
  assign trial = {rem_q, dvd_q[rwps_pkg::IDX_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIV_W'(diff);
      end else begin
        rem_d = DIV_W'(trial);
      end
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> src/rwps_cell.sv
// One sorting cell: keeps a descending order with its neighbors on insert, shifts down on select.
`timescale 1ns / 1ps

module rwps_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rwps_pkg::rwps_cell_ctrl_t   ctrl_i,
  input  logic [rwps_pkg::DATA_W-1:0] ins_value_i,
  input  rwps_pkg::rwps_slot_t        left_i,
  input  logic                        left_cmp_i,
  input  rwps_pkg::rwps_slot_t        right_i,
  output rwps_pkg::rwps_slot_t        slot_o,
  output logic                        cmp_o
);

  logic                        valid_q, valid_d;
  logic [rwps_pkg::DATA_W-1:0] value_q, value_d;

  // Incoming sample belongs above this cell's entry (an empty cell ranks lowest)
  assign cmp_o = !valid_q || ($signed(ins_value_i) > $signed(value_q));

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert) begin
      if (cmp_o) begin
        if (left_cmp_i) begin
          valid_d = left_i.valid;
          value_d = left_i.value;
        end else begin
          valid_d = 1'b1;
          value_d = ins_value_i;
        end
      end
    end else if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.value = value_q;

endmodule

>>> src/ring_window_percentile_select_core.sv
// Top level: sample ring, remainder unit, sorting cell chain and sequencer.
//
//  channel   ports                                   transfer when
//  -------   -------------------------------------   ---------------------------
//  command   start, busy, item_i                     start high, busy low
//  result    done_o, result_o                        done_o high (one cycle)
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i    cfg_valid_i and cfg_ready_o
//
// A write holds the item, then does the memory write before the next transfer.
// Only a ring depth that is neither a power of two nor above the slot range
// folds the slot through the remainder unit. A query with begin below end for
// a window of n samples runs the bit-serial remainder unit, then one ring read
// per cycle into the cell chain, a drain step, then shifts down to the
// selected rank and the result. A single-sample query reads one ring sample;
// an over-long window answers the cycle after acceptance. Reset leaves the
// ring contents undefined and the ring length at 1024. The receiver cannot
// stall a result.
`timescale 1ns / 1ps

module ring_window_percentile_select_core #(
  parameter int unsigned RING_DEPTH = rwps_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_WINDOW = rwps_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rwps_pkg::rwps_item_t       item_i,
  output logic                       done_o,
  output rwps_pkg::rwps_result_t     result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rwps_pkg::LEN_W-1:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned LENW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NW   = rwps_pkg::IDX_W + 1;
  localparam int unsigned WW   = 17;
  // Slots need folding only for a depth that is not a power of two and below the slot range
  localparam bit SLOT_FOLD = ((RING_DEPTH & (RING_DEPTH - 1)) != 0) &&
                             (RING_DEPTH < (32'd1 << rwps_pkg::SLOT_W));

  rwps_pkg::rwps_state_e       state_q, state_d;
  rwps_pkg::rwps_item_t        item_q;
  rwps_pkg::rwps_result_t      res_q, res_d;
  logic                        done_q, done_d;
  logic [rwps_pkg::LEN_W-1:0]  len_q;
  logic [AW-1:0]               addr_q, addr_d;
  logic [CW-1:0]               rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]               sh_cnt_q, sh_cnt_d;
  logic                        rd_vld_q, rd_vld_d;

  logic                        accept;
  logic                        in_single;
  logic                        in_too_long;
  logic [NW-1:0]               n_full;
  logic [CW-1:0]               n_win;
  logic [CW+1:0]               three_n;
  logic [CW-1:0]               k_rank;
  logic [CW-1:0]               sel_from_top;
  logic [LENW-1:0]             len_eff;
  logic [AW:0]                 addr_inc;
  logic [AW-1:0]               addr_next;

  logic                        mod_start;
  logic [rwps_pkg::IDX_W-1:0]  mod_dividend;
  logic [LENW-1:0]             mod_divisor;
  logic                        mod_done;
  logic [LENW-1:0]             mod_rem;

  logic                        ring_we;
  logic                        ring_re;
  logic [AW-1:0]               ring_waddr;
  logic [rwps_pkg::DATA_W-1:0] ring_rdata;

  rwps_pkg::rwps_cell_ctrl_t   cell_ctrl;
  rwps_pkg::rwps_slot_t        chain_slot [MAX_WINDOW];
  logic                        chain_cmp  [MAX_WINDOW];

  // Command decode on the incoming item
  assign accept      = start && !busy;
  assign in_single   = item_i.window_begin >= item_i.window_end;
  assign n_full      = {1'b0, item_i.window_end} - {1'b0, item_i.window_begin} + NW'(1);
  assign in_too_long = n_full > NW'(MAX_WINDOW);
  assign n_win       = CW'(n_full);

  // Rank counted from the largest: n - 1 - floor(3n/4)
  assign three_n      = {2'b00, n_win} + {1'b0, n_win, 1'b0};
  assign k_rank       = CW'(three_n >> 2);
  assign sel_from_top = n_win - k_rank - CW'(1);

  // Ring length in use: zero reads as one, saturate at the ring depth
  always_comb begin
    if (len_q == '0) begin
      len_eff = LENW'(1);
    end else if ({6'b0, len_q} > WW'(RING_DEPTH)) begin
      len_eff = LENW'(RING_DEPTH);
    end else begin
      len_eff = LENW'(len_q);
    end
  end

  // Advance the window address with wrap at the ring length
  assign addr_inc  = {1'b0, addr_q} + (AW + 1)'(1);
  assign addr_next = ((LENW + 1)'(addr_inc) == {1'b0, len_eff}) ? '0 : addr_q + AW'(1);

  // Remainder operands: the slot folds by the ring depth, the window start by the length
  assign mod_dividend = (item_i.cmd == rwps_pkg::CMD_WRITE) ?
                        rwps_pkg::IDX_W'(item_i.write_slot) : item_i.window_begin;
  assign mod_divisor  = (item_i.cmd == rwps_pkg::CMD_WRITE) ? LENW'(RING_DEPTH) : len_eff;

  // Write address: the held slot, masked by the depth, or the folded remainder
  assign ring_waddr = SLOT_FOLD ? AW'(mod_rem) : AW'(item_q.write_slot);

  rwps_mod #(
    .DIV_W (LENW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  rwps_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (item_q.sample_value),
    .re_i    (ring_re),
    .raddr_i (addr_q),
    .rdata_o (ring_rdata)
  );

  // Chain of sorting cells, largest sample in cell 0
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_chain
    rwps_pkg::rwps_slot_t left_slot;
    rwps_pkg::rwps_slot_t right_slot;
    logic                 left_cmp;

    if (g == 0) begin : g_head
      assign left_slot = '0;
      assign left_cmp  = 1'b0;
    end else begin : g_body
      assign left_slot = chain_slot[g-1];
      assign left_cmp  = chain_cmp[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = chain_slot[g+1];
    end

    rwps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .ins_value_i (ring_rdata),
      .left_i      (left_slot),
      .left_cmp_i  (left_cmp),
      .right_i     (right_slot),
      .slot_o      (chain_slot[g]),
      .cmp_o       (chain_cmp[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rwps_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_i.cmd == rwps_pkg::CMD_WRITE) begin
            state_d = rwps_pkg::ST_MOD_WRITE;
          end else if (in_single || !in_too_long) begin
            state_d = rwps_pkg::ST_MOD_QUERY;
          end
        end
      end
      rwps_pkg::ST_MOD_WRITE: begin
        if (mod_done || !SLOT_FOLD) begin
          state_d = rwps_pkg::ST_IDLE;
        end
      end
      rwps_pkg::ST_MOD_QUERY: begin
        if (mod_done) begin
          if (item_q.window_begin >= item_q.window_end) begin
            state_d = rwps_pkg::ST_SINGLE_RD;
          end else begin
            state_d = rwps_pkg::ST_FILL;
          end
        end
      end
      rwps_pkg::ST_SINGLE_RD: state_d = rwps_pkg::ST_SINGLE_OUT;
      rwps_pkg::ST_SINGLE_OUT: state_d = rwps_pkg::ST_IDLE;
      rwps_pkg::ST_FILL: begin
        if (rd_cnt_q == CW'(1)) begin
          state_d = rwps_pkg::ST_DRAIN;
        end
      end
      rwps_pkg::ST_DRAIN: state_d = rwps_pkg::ST_SELECT;
      rwps_pkg::ST_SELECT: begin
        if (sh_cnt_q == '0) begin
          state_d = rwps_pkg::ST_IDLE;
        end
      end
      default: state_d = rwps_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    mod_start        = 1'b0;
    ring_we          = 1'b0;
    ring_re          = 1'b0;
    cell_ctrl.clear  = 1'b0;
    cell_ctrl.insert = rd_vld_q;
    cell_ctrl.shift  = 1'b0;
    rd_vld_d         = 1'b0;
    addr_d           = addr_q;
    rd_cnt_d         = rd_cnt_q;
    sh_cnt_d         = sh_cnt_q;
    done_d           = 1'b0;
    res_d            = res_q;
    case (state_q)
      rwps_pkg::ST_IDLE: begin
        if (accept) begin
          rd_cnt_d = n_win;
          sh_cnt_d = sel_from_top;
          if (item_i.cmd == rwps_pkg::CMD_QUERY && !in_single && in_too_long) begin
            done_d                = 1'b1;
            res_d.reference_value = '0;
            res_d.window_too_long = 1'b1;
          end else if (item_i.cmd == rwps_pkg::CMD_QUERY || SLOT_FOLD) begin
            mod_start = 1'b1;
          end
        end
      end
      rwps_pkg::ST_MOD_WRITE: begin
        ring_we = mod_done || !SLOT_FOLD;
      end
      rwps_pkg::ST_MOD_QUERY: begin
        cell_ctrl.clear = 1'b1;
        if (mod_done) begin
          addr_d = AW'(mod_rem);
        end
      end
      rwps_pkg::ST_SINGLE_RD: begin
        ring_re = 1'b1;
      end
      rwps_pkg::ST_SINGLE_OUT: begin
        done_d                = 1'b1;
        res_d.reference_value = $signed(ring_rdata);
        res_d.window_too_long = 1'b0;
      end
      rwps_pkg::ST_FILL: begin
        ring_re  = 1'b1;
        rd_vld_d = 1'b1;
        addr_d   = addr_next;
        rd_cnt_d = rd_cnt_q - CW'(1);
      end
      rwps_pkg::ST_DRAIN: begin
        rd_vld_d = 1'b0;
      end
      rwps_pkg::ST_SELECT: begin
        if (sh_cnt_q == '0) begin
          done_d                = 1'b1;
          res_d.reference_value = $signed(chain_slot[0].value);
          res_d.window_too_long = 1'b0;
        end else begin
          cell_ctrl.shift = 1'b1;
          sh_cnt_d        = sh_cnt_q - CW'(1);
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rwps_pkg::ST_IDLE;
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_cnt_q <= '0;
      sh_cnt_q <= '0;
      addr_q   <= '0;
      len_q    <= rwps_pkg::LEN_RESET;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      rd_vld_q <= rd_vld_d;
      rd_cnt_q <= rd_cnt_d;
      sh_cnt_q <= sh_cnt_d;
      addr_q   <= addr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  assign busy        = state_q != rwps_pkg::ST_IDLE;
  assign cfg_ready_o = state_q == rwps_pkg::ST_IDLE;
  assign done_o      = done_q;
  assign result_o    = res_q;

  // A result is only shown once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // The flagged answer always carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.window_too_long) |-> (result_o.reference_value == '0))
    else $error("too-long result with nonzero value");

  // An insert never pushes a sample off the end of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.insert |-> !chain_slot[MAX_WINDOW-1].valid)
    else $error("cell chain overflow on insert");

  // The selected rank always lies inside the filled part of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rwps_pkg::ST_SELECT) |-> chain_slot[0].valid)
    else $error("selection reached an empty cell");

endmodule
